@@ src/encav_pkg.sv @@
// shared constants for the encoder angle and velocity estimator
package encav_pkg;

    // field widths of the stream items
    localparam int POS_IN_W  = 14;
    localparam int TIME_W    = 32;
    localparam int ANGLE_W   = 19;
    localparam int VEL_W     = 29;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // quotient bits kept by the divider (bits at and above the rounding bit)
    localparam int QUO_W = 29;

    // iteration counter, wide enough for the divider and the longest multiply
    localparam int CNT_W = 5;

    // 2*pi in Q29
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    // 2*pi in Q29 times milliseconds per second
    localparam int VEL_K_W = 42;
    localparam logic [VEL_K_W-1:0] VEL_K = 42'd3373259426000;

    // velocity clamp in Q16 rad/s
    localparam logic [VEL_W-1:0] VEL_SAT = 29'd205887418;

endpackage

@@ src/encoder_angle_velocity_estimator_unit.sv @@
// encoder angle and velocity estimator, top level
// Requests are handled one at a time: s_tready is high only while idle, so a new request is
// taken only after the previous result has been loaded into the output register. The angle
// and, when the velocity is recomputed, the velocity share a single shift-add multiplier;
// a one-bit-per-cycle restoring divider follows it. Reset (aresetn low, synchronous)
// clears the previous sample, the held velocity and all handshake state.
module encoder_angle_velocity_estimator_unit
    import encav_pkg::*;
#(
    parameter int POSITION_BITS = 14
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: position_sample[13:0], time_ms[45:14], zero fill [47:46]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // m_tdata: angle_q16[18:0], velocity_q16[47:19]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: velocity_updated[0], zero_interval[1]
    output logic [M_TUSER_W-1:0]  m_tuser
);

    // derived widths
    localparam int PB      = POSITION_BITS;
    localparam int SHIFT   = PB + 13;
    localparam int PROD_W  = PB + 41;
    localparam int POS_X_W = (PB > POS_IN_W) ? PB : POS_IN_W;

    localparam logic [PB-1:0]    HALF_TURN = {1'b1, {(PB-1){1'b0}}};
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(PB - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANG_MUL,
        ST_ANG_RND,
        ST_VEL_MUL,
        ST_DIV,
        ST_VEL_RND,
        ST_FINISH
    } state_t;

    state_t               state_reg;

    // stored previous sample and held velocity
    logic [PB-1:0]        prev_pos_reg;
    logic [TIME_W-1:0]    prev_time_reg;
    logic [VEL_W-1:0]     vel_reg;

    // per-request working registers
    logic [PB-1:0]        mag_reg;
    logic                 neg_reg;
    logic                 upd_reg;
    logic                 zero_reg;
    logic [TIME_W-1:0]    dt_reg;
    logic [ANGLE_W-1:0]   angle_reg;

    // shared shift-add multiplier
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    acc_next;
    logic [PROD_W-1:0]    mcand_reg;
    logic [PB-1:0]        mplier_reg;
    logic [CNT_W-1:0]     cnt_reg;

    // restoring divider
    logic [TIME_W-1:0]    rem_reg;
    logic [TIME_W-1:0]    rem_next;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_W-1:0]     quo_next;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      trial_diff;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    // request decode
    logic [POS_X_W-1:0]   pos_ext;
    logic [PB-1:0]        pos_in;
    logic [TIME_W-1:0]    time_in;
    logic [PB-1:0]        diff_u;
    logic                 diff_neg;
    logic [PB-1:0]        diff_mag;
    logic [TIME_W-1:0]    dt_in;
    logic                 accept;
    logic                 out_free;

    // velocity rounding and clamp
    logic [QUO_W-1:0]     vel_rnd;
    logic [VEL_W-1:0]     vel_clamp;
    logic [VEL_W-1:0]     vel_final;
    logic [VEL_W-1:0]     vel_sat_signed;
    logic [ANGLE_W-1:0]   angle_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // unpack request and unwrap the position step
    always_comb begin
        pos_ext  = POS_X_W'(s_tdata[POS_IN_W-1:0]);
        pos_in   = pos_ext[PB-1:0];
        time_in  = s_tdata[POS_IN_W +: TIME_W];
        diff_u   = pos_in - prev_pos_reg;
        diff_neg = (diff_u > HALF_TURN);
        diff_mag = diff_neg ? (PB'(0) - diff_u) : diff_u;
        dt_in    = time_in - prev_time_reg;
    end

    // multiplier and divider step
    always_comb begin
        acc_next   = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
        trial      = {rem_reg, quo_reg[QUO_W-1]};
        trial_diff = trial - {1'b0, dt_reg};
        if (!trial_diff[TIME_W]) begin
            rem_next = trial_diff[TIME_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], 1'b1};
        end else begin
            rem_next = trial[TIME_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], 1'b0};
        end
    end

    // rounding of angle and velocity
    always_comb begin
        angle_next     = acc_reg[SHIFT +: ANGLE_W] + ANGLE_W'(acc_reg[SHIFT-1]);
        vel_rnd        = {1'b0, quo_reg[QUO_W-1:1]} + QUO_W'(quo_reg[0]);
        vel_clamp      = (vel_rnd > VEL_SAT) ? VEL_SAT : vel_rnd;
        vel_final      = neg_reg ? (VEL_W'(0) - vel_clamp) : vel_clamp;
        vel_sat_signed = (mag_reg == '0) ? '0 :
                         (neg_reg ? (VEL_W'(0) - VEL_SAT) : VEL_SAT);
    end

    // sequencer, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_pos_reg  <= '0;
            prev_time_reg <= '0;
            vel_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            // the finish state reloads the output register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        mag_reg       <= diff_mag;
                        neg_reg       <= diff_neg;
                        upd_reg       <= (prev_time_reg != '0);
                        zero_reg      <= (prev_time_reg != '0) && (dt_in == '0);
                        dt_reg        <= dt_in;
                        prev_pos_reg  <= pos_in;
                        prev_time_reg <= time_in;
                        acc_reg       <= '0;
                        mcand_reg     <= PROD_W'(TWO_PI_Q29);
                        mplier_reg    <= pos_in;
                        cnt_reg       <= '0;
                        state_reg     <= ST_ANG_MUL;
                    end
                end
                ST_ANG_MUL: begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST) begin
                        state_reg <= ST_ANG_RND;
                    end
                end
                ST_ANG_RND: begin
                    angle_reg <= angle_next;
                    if (!upd_reg) begin
                        state_reg <= ST_FINISH;
                    end else if (zero_reg) begin
                        vel_reg   <= vel_sat_signed;
                        state_reg <= ST_FINISH;
                    end else begin
                        acc_reg    <= '0;
                        mcand_reg  <= PROD_W'(VEL_K);
                        mplier_reg <= mag_reg;
                        cnt_reg    <= '0;
                        state_reg  <= ST_VEL_MUL;
                    end
                end
                ST_VEL_MUL: begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    if (cnt_reg == MUL_LAST) begin
                        // dividend is the product from the rounding bit upward
                        quo_reg   <= acc_next[SHIFT-1 +: QUO_W];
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST) begin
                        state_reg <= ST_VEL_RND;
                    end
                end
                ST_VEL_RND: begin
                    vel_reg   <= vel_final;
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {vel_reg, angle_reg};
                        m_tuser_reg  <= {zero_reg, upd_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/tb_encoder_angle_velocity_estimator_unit.sv @@
// testbench for the encoder angle and velocity estimator: random motion, stalls, self-checking
`timescale 1ns / 100ps

module tb_encoder_angle_velocity_estimator_unit
    import encav_pkg::*;
();

    localparam int         Q_SHIFT      = POS_IN_W + 13;
    localparam int         HALF_TURN    = 1 << (POS_IN_W - 1);
    localparam int         FULL_TURN    = 1 << POS_IN_W;
    localparam int         RANDOM_ITEMS = 1050;
    localparam int         LONG_HOLD    = 600;
    localparam int         TAIL_CYCLES  = 100;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // one expected result
    typedef struct {
        logic [ANGLE_W-1:0]        angle;
        logic signed [VEL_W-1:0]   velocity;
        logic                      updated;
        logic                      zero_dt;
    } motion_t;

    // tracks previous sample and held velocity, queues expected results
    class motion_scoreboard;
        logic [POS_IN_W-1:0]       last_pos;
        logic [TIME_W-1:0]         last_time;
        logic signed [VEL_W-1:0]   held_vel;
        motion_t                   pending_motion[$];
        int                        mismatches;

        function new();
            last_pos   = '0;
            last_time  = '0;
            held_vel   = '0;
            mismatches = 0;
        endfunction

        // work out angle and velocity for an accepted request
        function void predict_motion(input logic [POS_IN_W-1:0] pos,
                                     input logic [TIME_W-1:0] now);
            motion_t             want;
            longint unsigned     prod;
            longint unsigned     mag;
            longint unsigned     q;
            longint              sat;
            longint              v;
            int                  diff;
            logic [POS_IN_W-1:0] u;
            logic [TIME_W-1:0]   dt;

            sat  = longint'(VEL_SAT);
            prod = 64'(pos) * 64'(TWO_PI_Q29);
            want.angle   = ANGLE_W'((prod >> Q_SHIFT) + ((prod >> (Q_SHIFT - 1)) & 64'd1));
            want.updated = 1'b0;
            want.zero_dt = 1'b0;

            // no velocity update while the stored timestamp is zero
            if (last_time != '0) begin
                dt = now - last_time;
                u  = pos - last_pos;
                // half a turn counts as a forward step
                if (int'(u) <= HALF_TURN) diff = int'(u);
                else diff = int'(u) - FULL_TURN;
                if (dt == '0) begin
                    v = (diff > 0) ? sat : (diff < 0) ? -sat : 0;
                end else begin
                    mag = 64'((diff < 0) ? -diff : diff);
                    q   = (mag * 64'(VEL_K)) / 64'(dt);
                    q   = (q >> Q_SHIFT) + ((q >> (Q_SHIFT - 1)) & 64'd1);
                    if (q > 64'(sat)) q = 64'(sat);
                    v = (diff < 0) ? -longint'(q) : longint'(q);
                end
                held_vel     = VEL_W'(v);
                want.updated = 1'b1;
                want.zero_dt = (dt == '0);
            end
            want.velocity = held_vel;
            last_pos  = pos;
            last_time = now;
            pending_motion.push_back(want);
        endfunction

        task report_mismatch(input string line);
            $display("%0t: mismatch: %s", $realtime, line);
            mismatches++;
        endtask

        // compare an accepted result with the oldest expectation
        task check_motion(input logic [M_TDATA_W-1:0] tdata,
                          input logic [M_TUSER_W-1:0] tuser);
            motion_t                 want;
            logic [ANGLE_W-1:0]      got_angle;
            logic signed [VEL_W-1:0] got_vel;

            got_angle = tdata[ANGLE_W-1:0];
            got_vel   = tdata[ANGLE_W +: VEL_W];
            if (pending_motion.size() == 0) begin
                report_mismatch($sformatf("unexpected result angle %0d velocity %0d",
                                          got_angle, got_vel));
                return;
            end
            want = pending_motion.pop_front();
            if (got_angle !== want.angle)
                report_mismatch($sformatf("angle got %0d expected %0d", got_angle, want.angle));
            if (got_vel !== want.velocity)
                report_mismatch($sformatf("velocity got %0d expected %0d",
                                          got_vel, want.velocity));
            if (tuser[0] !== want.updated)
                report_mismatch($sformatf("velocity_updated got %0b expected %0b",
                                          tuser[0], want.updated));
            if (tuser[1] !== want.zero_dt)
                report_mismatch($sformatf("zero_interval got %0b expected %0b",
                                          tuser[1], want.zero_dt));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;

    motion_scoreboard      board;
    int                    samples_sent;
    int                    results_seen;
    int                    burst_left;

    encoder_angle_velocity_estimator_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("tb_encoder_angle_velocity_estimator_unit failed");
        $finish;
    end

    // offer one sample, wait for the request to be taken, then maybe pause
    task automatic offer_sample(input logic [POS_IN_W-1:0] pos, input logic [TIME_W-1:0] now);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - POS_IN_W - TIME_W){1'b0}}, now, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.predict_motion(pos, now);
        samples_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // corner cases: first sample, zero timestamps, zero interval, half turns, wraps
    task automatic run_directed();
        offer_sample(14'd0, 32'd0);
        offer_sample(14'h3FFF, 32'd5);
        offer_sample(14'h3FFF, 32'd5);
        offer_sample(14'd100, 32'd5);
        offer_sample(14'd50, 32'd5);
        offer_sample(14'd8242, 32'd6);
        offer_sample(14'd50, 32'd7);
        offer_sample(14'd51, TIME_MAX);
        offer_sample(14'd60, 32'd2);
        offer_sample(14'd8253, 32'd1002);
        offer_sample(14'd60, 32'd2002);
        offer_sample(14'd0, 32'h8000_0000);
        offer_sample(14'd1, 32'h8000_0001);
        offer_sample(14'h3FFF, 32'h8000_0002);
        offer_sample(14'd0, 32'd0);
        offer_sample(14'd200, 32'd10);
        offer_sample(14'd300, 32'd9);
        offer_sample(14'h2AAA, 32'hAAAA_AAAA);
        offer_sample(14'h1555, 32'h5555_5555);
        offer_sample(14'h1555, 32'h5555_5556);
        offer_sample(14'h3FFF, 32'h5555_5557);
    endtask

    // mostly smooth motion tracks, some noise and broken timestamps
    task automatic run_random_motion(input int stop_at);
        logic [POS_IN_W-1:0] pos;
        logic [TIME_W-1:0]   now;
        int                  len;
        int                  rate_mode;
        int                  speed;
        int                  step_p;
        int                  step_t;

        now = $urandom;
        pos = POS_IN_W'($urandom_range(0, FULL_TURN - 1));
        while (samples_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                len       = $urandom_range(8, 60);
                rate_mode = $urandom_range(0, 3);
                speed     = $urandom_range(0, 400) - 200;
                pos       = POS_IN_W'($urandom_range(0, FULL_TURN - 1));
                if ($urandom_range(0, 9) == 0) now = TIME_MAX - $urandom_range(0, 40);
                else now = $urandom;
                repeat (len) begin
                    case (rate_mode)
                        0: begin
                            step_t = $urandom_range(1, 3);
                            step_p = speed + $urandom_range(0, 8) - 4;
                        end
                        1: begin
                            step_t = $urandom_range(1, 1000);
                            step_p = speed * 8 + $urandom_range(0, 64) - 32;
                        end
                        2: begin
                            step_t = $urandom_range(0, 2);
                            step_p = $urandom_range(0, 6) - 3;
                        end
                        default: begin
                            step_t = $urandom_range(1, 20);
                            step_p = ($urandom_range(0, 4) == 0) ? HALF_TURN
                                                                 : $urandom_range(0, FULL_TURN - 1);
                        end
                    endcase
                    now = now + TIME_W'(step_t);
                    pos = pos + POS_IN_W'(step_p);
                    offer_sample(pos, now);
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0: now = '0;
                        1: now = $urandom;
                        2: ;
                        default: now = now + 32'd1;
                    endcase
                    pos = POS_IN_W'($urandom_range(0, FULL_TURN - 1));
                    offer_sample(pos, now);
                end
            end
        end
    endtask

    // reset, stimulus and end of run
    initial begin
        board        = new();
        samples_sent = 0;
        burst_left   = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random_motion(samples_sent + RANDOM_ITEMS);
        s_tvalid <= 1'b0;

        while (board.pending_motion.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_motion.size() == 0) begin
            $display("tb_encoder_angle_velocity_estimator_unit passed");
        end else begin
            $display("tb_encoder_angle_velocity_estimator_unit failed");
        end
        $finish;
    end

    // result side stall patterns, with one long hold-off
    initial begin : result_sink
        int  mode;
        int  run_len;
        int  phase;
        bit  long_hold_done;

        long_hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= 150) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            mode    = $urandom_range(0, 4);
            run_len = $urandom_range(1, 300);
            phase   = 0;
            repeat (run_len) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    3: m_tready <= ($urandom_range(0, 5) == 0);
                    default: m_tready <= (phase % 7) < 3;
                endcase
                phase++;
                @(posedge aclk);
            end
        end
    end

    // result monitor
    initial results_seen = 0;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_motion(m_tdata, m_tuser);
            results_seen++;
        end
    end

endmodule
